// ===== rtl/core/rbvf_pkg.sv =====
// Shared types, widths and constants of the rough Bergomi variance factor unit.
package rbvf_pkg;

	// time grid
	localparam int MAX_STEPS = 4096;
	localparam int IDX_W     = $clog2(MAX_STEPS);
	localparam int T_W       = IDX_W + 1 + 32;

	// log2 unit: one normalize stage, then one squaring per fraction bit
	localparam int FRAC_W     = 26;
	localparam int LOG_STAGES = FRAC_W + 1;
	localparam int LANES      = 3;
	localparam int LANE_T     = 0;
	localparam int LANE_ETA   = 1;
	localparam int LANE_XI    = 2;
	localparam int LOG_W      = 34;
	localparam logic [7:0] FB_T   = 8'd32;
	localparam logic [7:0] FB_Q24 = 8'd24;

	// exp2 unit: argument split, then multiply / reciprocal / correct per term
	localparam int Z_W        = 40;
	localparam int N_W        = Z_W - FRAC_W;
	localparam int EXP_TERMS  = 12;
	localparam int EXP_STAGES = 1 + 3 * EXP_TERMS;

	localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	localparam int E_W = 37;
	localparam logic [36:0] DRIFT_MAX = 37'h10_0000_0000;
	localparam logic [47:0] OUT_MAX   = 48'hFFFF_FFFF_FFFF;

	// register map, word index
	typedef enum logic [2:0] {
		REG_VOL_OF_VOL  = 3'd0,
		REG_TWICE_HURST = 3'd1,
		REG_TIME_STEP   = 3'd2,
		REG_FLAT_FWD    = 3'd3,
		REG_USE_CURVE   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] bh_level;
		logic [11:0]        step_index;
		logic signed [31:0] curve_variance;
	} item_t;

	typedef struct packed {
		logic [47:0] variance_factor;
		logic        status;
	} result_t;

	// per-item data that rides along with the arithmetic units
	typedef struct packed {
		logic signed [E_W-1:0]   e;
		logic                    status;
		logic                    zero;
		logic                    dzero;
		logic                    tzero;
		logic signed [LOG_W-1:0] log_eta;
		logic signed [LOG_W-1:0] log_xi0;
	} side_t;

endpackage

// ===== rtl/core/rbvf_log2.sv =====
// Pipelined three-lane log2: top-bit normalize, then one mantissa squaring per stage.
module rbvf_log2 (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_i,
	input  logic [rbvf_pkg::LANES-1:0][rbvf_pkg::T_W-1:0] val_i,
	input  rbvf_pkg::side_t side_i,
	output logic valid_o,
	output logic [rbvf_pkg::LANES-1:0][5:0] kint_o,
	output logic [rbvf_pkg::LANES-1:0][rbvf_pkg::FRAC_W-1:0] frac_o,
	output rbvf_pkg::side_t side_o
);

	localparam int NS = rbvf_pkg::LOG_STAGES;
	localparam int NL = rbvf_pkg::LANES;
	localparam int FW = rbvf_pkg::FRAC_W;
	localparam int TW = rbvf_pkg::T_W;

	logic [NS-1:0]              v_s;
	rbvf_pkg::side_t            side_s [NS];
	logic [NL-1:0][5:0]         k_s    [NS];
	logic [NL-1:0][30:0]        m_s    [NS];
	logic [NL-1:0][FW-1:0]      r_s    [NS];
	logic [NL-1:0][61:0]        sq_c   [NS-1];
	logic [NL-1:0][5:0]         k0_c;
	logic [NL-1:0][TW+29:0]     wide_c;

	// index of the highest set bit, zero for zero and one
	function automatic logic [5:0] top_bit(input logic [TW-1:0] v);
		logic [5:0] k;
		k = '0;
		for (int b = 1; b < TW; b++) begin
			if (v[b]) k = 6'(b);
		end
		return k;
	endfunction

	// normalize to a Q1.30 mantissa
	for (genvar l = 0; l < NL; l++) begin : g_norm
		assign k0_c[l]   = top_bit(val_i[l]);
		assign wide_c[l] = {val_i[l], 30'b0} >> k0_c[l];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NS-2:0], valid_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_i;
			for (int l = 0; l < NL; l++) begin
				k_s[0][l] <= k0_c[l];
				m_s[0][l] <= wide_c[l][30:0];
				r_s[0][l] <= '0;
			end
		end
	end

	// one fraction bit per stage: square, renormalize when at or above two
	for (genvar s = 1; s < NS; s++) begin : g_iter
		for (genvar l = 0; l < NL; l++) begin : g_lane
			assign sq_c[s-1][l] = 62'(m_s[s-1][l]) * 62'(m_s[s-1][l]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[s] <= side_s[s-1];
				for (int l = 0; l < NL; l++) begin
					k_s[s][l] <= k_s[s-1][l];
					m_s[s][l] <= sq_c[s-1][l][61] ? sq_c[s-1][l][61:31] : sq_c[s-1][l][60:30];
					r_s[s][l] <= {r_s[s-1][l][FW-2:0], sq_c[s-1][l][61]};
				end
			end
		end
	end

	assign valid_o = v_s[NS-1];
	assign kint_o  = k_s[NS-1];
	assign frac_o  = r_s[NS-1];
	assign side_o  = side_s[NS-1];

endmodule

// ===== rtl/core/rbvf_exp2.sv =====
// Pipelined exp2 of a Q.26 argument: 12-term series of 2^frac, integer part passed on.
module rbvf_exp2 (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_i,
	input  logic [rbvf_pkg::Z_W-1:0] z_i,
	input  rbvf_pkg::side_t side_i,
	output logic valid_o,
	output logic signed [rbvf_pkg::N_W-1:0] n_o,
	output logic [31:0] sum_o,
	output rbvf_pkg::side_t side_o
);

	localparam int ES = rbvf_pkg::EXP_STAGES;
	localparam int NT = rbvf_pkg::EXP_TERMS;
	localparam int FW = rbvf_pkg::FRAC_W;
	localparam int NW = rbvf_pkg::N_W;

	logic [ES-1:0]          v_s;
	rbvf_pkg::side_t        side_s [ES];
	logic signed [NW-1:0]   n_s    [ES];
	logic [29:0]            u_s    [ES];
	logic [31:0]            sum_s  [ES];
	logic [60:0]            prod_s [NT];
	logic [29:0]            p_s    [NT];
	logic [29:0]            q0_s   [NT];
	logic [30:0]            term_s [NT-1];
	logic [29:0]            q_c    [NT];
	logic [55:0]            uprod_c;

	// split into floor and fraction, fraction times ln2
	assign uprod_c = 56'(z_i[FW-1:0]) * 56'(rbvf_pkg::LN2_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[ES-2:0], valid_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_i;
			n_s[0]    <= z_i[rbvf_pkg::Z_W-1:FW];
			u_s[0]    <= uprod_c[55:26];
			sum_s[0]  <= 32'(rbvf_pkg::Q30_ONE);
		end
	end

	// carried fields; the running sum picks up a term at each correction stage
	for (genvar s = 1; s < ES; s++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[s] <= side_s[s-1];
				n_s[s]    <= n_s[s-1];
				u_s[s]    <= u_s[s-1];
			end
		end

		if (s % 3 == 0) begin : g_add
			always_ff @(posedge clk) begin
				if (en) begin
					sum_s[s] <= sum_s[s-1] + {2'b0, q_c[s/3-1]};
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (en) begin
					sum_s[s] <= sum_s[s-1];
				end
			end
		end
	end

	// term k = (term k-1 * u >> 30) / k
	for (genvar j = 0; j < NT; j++) begin : g_term
		localparam int K = j + 1;
		localparam logic [31:0] RK = 32'(64'hFFFF_FFFF / K);
		localparam logic [3:0] KV = 4'(K);

		logic [30:0] tin;
		logic [61:0] qprod;
		logic [33:0] kq;
		logic [29:0] rem;

		if (j == 0) begin : g_first
			assign tin = rbvf_pkg::Q30_ONE;
		end else begin : g_next
			assign tin = term_s[j-1];
		end

		// multiply by u
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s[j] <= 61'(tin) * 61'(u_s[3*j]);
			end
		end

		// quotient estimate by reciprocal, at most one low
		assign qprod = 62'(prod_s[j][59:30]) * 62'(RK);

		always_ff @(posedge clk) begin
			if (en) begin
				p_s[j]  <= prod_s[j][59:30];
				q0_s[j] <= qprod[61:32];
			end
		end

		// one-step correction
		assign kq     = 34'(q0_s[j]) * 34'(KV);
		assign rem    = p_s[j] - kq[29:0];
		assign q_c[j] = (rem >= 30'(KV)) ? q0_s[j] + 30'd1 : q0_s[j];

		if (j < NT - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					term_s[j] <= {1'b0, q_c[j]};
				end
			end
		end
	end

	assign valid_o = v_s[ES-1];
	assign n_o     = n_s[ES-1];
	assign sum_o   = sum_s[ES-1];
	assign side_o  = side_s[ES-1];

endmodule

// ===== rtl/core/rough_bergomi_variance_factor_unit.sv =====
// Top level: rough Bergomi forward-variance factor xi0*exp(eta*bh - 0.5*eta^2*t^2H).
//
// Item channel (item_valid/item_ready/item) takes one fractional Brownian level,
// its step index and a curve value per beat; result channel (result_valid/
// result_ready/result) returns one variance factor and status per item, in order.
// Registers sit on an APB-style port at word addresses 0..4; pready is always
// high and writes are meant for idle periods.
// Throughput: one item per cycle while the output is not stalled. The path runs
// through the 27-stage log2 pipeline and the two 37-stage exp2 pipelines (each an
// argument split stage, then three stages per term of the 12-term series).
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// When the receiver stalls, the whole pipeline freezes once a further result
// reaches the full output register: that result parks in a skid register and
// item_ready drops until it drains. Nothing is lost or repeated.
module rough_bergomi_variance_factor_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  rbvf_pkg::item_t item,
	output logic result_valid,
	input  logic result_ready,
	output rbvf_pkg::result_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int TW = rbvf_pkg::T_W;
	localparam int ZW = rbvf_pkg::Z_W;
	localparam int LW = rbvf_pkg::LOG_W;
	localparam logic signed [ZW-1:0] Q26_ONE = 40'sh400_0000;
	localparam logic signed [37:0]   X_LO    = -38'sd1073741824;
	localparam logic signed [37:0]   X_HI    = 38'sd536870912;

	// configuration
	logic [27:0] vol_q;
	logic [30:0] th_q;
	logic [31:0] dt_q;
	logic [30:0] flat_q;
	logic        curve_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q   <= 28'd16777216;
			th_q    <= 31'd107374182;
			dt_q    <= 32'd16777216;
			flat_q  <= 31'd671089;
			curve_q <= 1'b0;
		end else if (wr) begin
			case (paddr[4:2])
				rbvf_pkg::REG_VOL_OF_VOL:  vol_q   <= pwdata[27:0];
				rbvf_pkg::REG_TWICE_HURST: th_q    <= pwdata[30:0];
				rbvf_pkg::REG_TIME_STEP:   dt_q    <= pwdata;
				rbvf_pkg::REG_FLAT_FWD:    flat_q  <= pwdata[30:0];
				rbvf_pkg::REG_USE_CURVE:   curve_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			rbvf_pkg::REG_VOL_OF_VOL:  prdata = {4'b0, vol_q};
			rbvf_pkg::REG_TWICE_HURST: prdata = {1'b0, th_q};
			rbvf_pkg::REG_TIME_STEP:   prdata = dt_q;
			rbvf_pkg::REG_FLAT_FWD:    prdata = {1'b0, flat_q};
			rbvf_pkg::REG_USE_CURVE:   prdata = {31'b0, curve_q};
			default:                   prdata = '0;
		endcase
	end

	// pipeline advance and output skid
	logic en;
	logic res_valid_c;
	logic push;
	rbvf_pkg::result_t res_c;
	rbvf_pkg::result_t out_q;
	rbvf_pkg::result_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;

	assign en         = ~skid_valid_q;
	assign item_ready = en;
	assign push       = en & res_valid_c;

	// s1: time, eta*|bh|, xi0 choice and special-case flags
	logic [rbvf_pkg::IDX_W:0] idx1_c;
	logic [TW-1:0]            t_c;
	logic [31:0]              bh_u;
	logic [31:0]              bh_mag_c;
	logic [59:0]              eb_c;
	logic [30:0]              xi0_c;
	logic                     status_c;

	assign idx1_c   = {1'b0, item.step_index[rbvf_pkg::IDX_W-1:0]} + 1'b1;
	assign t_c      = TW'(idx1_c) * TW'(dt_q);
	assign bh_u     = item.bh_level;
	assign bh_mag_c = bh_u[31] ? ~bh_u + 32'd1 : bh_u;
	assign eb_c     = 60'(bh_mag_c) * 60'(vol_q);
	assign xi0_c    = curve_q ? item.curve_variance[30:0] : flat_q;
	assign status_c = curve_q & item.curve_variance[31];

	logic          v_s1;
	logic [TW-1:0] t_s1;
	logic [59:0]   eb_s1;
	logic          eb_neg_s1;
	logic [30:0]   xi0_s1;
	logic          status_s1;
	logic          zero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1      <= t_c;
			eb_s1     <= eb_c;
			eb_neg_s1 <= bh_u[31];
			xi0_s1    <= xi0_c;
			status_s1 <= status_c;
			zero_s1   <= ~status_c & (xi0_c == '0);
		end
	end

	// signed e = eta*bh >> 24, toward zero
	logic [36:0] e_mag_c;
	logic [36:0] e_c;
	rbvf_pkg::side_t side_in_c;
	logic [rbvf_pkg::LANES-1:0][TW-1:0] lval_c;

	assign e_mag_c = {1'b0, eb_s1[59:24]};
	assign e_c     = eb_neg_s1 ? ~e_mag_c + 37'd1 : e_mag_c;

	always_comb begin
		side_in_c         = '0;
		side_in_c.e       = e_c;
		side_in_c.status  = status_s1;
		side_in_c.zero    = zero_s1;
		side_in_c.tzero   = (t_s1 == '0);
		side_in_c.dzero   = (vol_q == '0) | ((t_s1 == '0) & (th_q != '0));
		lval_c[rbvf_pkg::LANE_T]   = t_s1;
		lval_c[rbvf_pkg::LANE_ETA] = TW'(vol_q);
		lval_c[rbvf_pkg::LANE_XI]  = TW'(xi0_s1);
	end

	logic                                            log_v;
	logic [rbvf_pkg::LANES-1:0][5:0]                 log_k;
	logic [rbvf_pkg::LANES-1:0][rbvf_pkg::FRAC_W-1:0] log_r;
	rbvf_pkg::side_t                                 log_side;

	rbvf_log2 u_log2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (v_s1),
		.val_i   (lval_c),
		.side_i  (side_in_c),
		.valid_o (log_v),
		.kint_o  (log_k),
		.frac_o  (log_r),
		.side_o  (log_side)
	);

	// s2: assemble Q.26 logs, |log2 t| * 2H
	logic [7:0]    int_t_c;
	logic [7:0]    int_e_c;
	logic [7:0]    int_x_c;
	logic [LW-1:0] logt_c;
	logic [LW-1:0] lt_mag_c;
	logic [62:0]   yprod_c;
	rbvf_pkg::side_t side2_c;

	assign int_t_c  = {2'b0, log_k[rbvf_pkg::LANE_T]} - rbvf_pkg::FB_T;
	assign int_e_c  = {2'b0, log_k[rbvf_pkg::LANE_ETA]} - rbvf_pkg::FB_Q24;
	assign int_x_c  = {2'b0, log_k[rbvf_pkg::LANE_XI]} - rbvf_pkg::FB_Q24;
	assign logt_c   = {int_t_c, log_r[rbvf_pkg::LANE_T]};
	assign lt_mag_c = logt_c[LW-1] ? ~logt_c + 34'd1 : logt_c;
	assign yprod_c  = 63'(lt_mag_c[31:0]) * 63'(th_q);

	always_comb begin
		side2_c         = log_side;
		side2_c.log_eta = {int_e_c, log_r[rbvf_pkg::LANE_ETA]};
		side2_c.log_xi0 = {int_x_c, log_r[rbvf_pkg::LANE_XI]};
	end

	logic            v_s2;
	logic [62:0]     yprod_s2;
	logic            yneg_s2;
	rbvf_pkg::side_t side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			yprod_s2 <= yprod_c;
			yneg_s2  <= logt_c[LW-1];
			side_s2  <= side2_c;
		end
	end

	// s3: z = 2*log2(eta) + y - 1
	logic [ZW-1:0]        ymag_c;
	logic signed [ZW-1:0] y_c;
	logic signed [ZW-1:0] le_c;
	logic signed [ZW-1:0] z_c;

	assign ymag_c = {7'b0, yprod_s2[62:30]};
	assign y_c    = side_s2.tzero ? '0 : (yneg_s2 ? ~ymag_c + 40'd1 : ymag_c);
	assign le_c   = ZW'(side_s2.log_eta);
	assign z_c    = (le_c <<< 1) + y_c - Q26_ONE;

	logic            v_s3;
	logic [ZW-1:0]   z_s3;
	rbvf_pkg::side_t side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s3    <= z_c;
			side_s3 <= side_s2;
		end
	end

	logic                          ea_v;
	logic signed [rbvf_pkg::N_W-1:0] ea_n;
	logic [31:0]                   ea_sum;
	rbvf_pkg::side_t               ea_side;

	rbvf_exp2 u_exp_drift (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (v_s3),
		.z_i     (z_s3),
		.side_i  (side_s3),
		.valid_o (ea_v),
		.n_o     (ea_n),
		.sum_o   (ea_sum),
		.side_o  (ea_side)
	);

	// series sum scaled by 2^s; all ones stands for overflow
	function automatic logic [63:0] scale(input logic signed [14:0] s, input logic [31:0] sum);
		logic [14:0] ns;
		logic [63:0] val;
		ns = 15'(-s);
		if (s > 15'sd32) begin
			val = '1;
		end else if (s >= 15'sd0) begin
			val = 64'(sum) << s[5:0];
		end else if (ns >= 15'd32) begin
			val = '0;
		end else begin
			val = 64'(sum >> ns[4:0]);
		end
		return val;
	endfunction

	// s4: drift in Q.24, saturated
	logic signed [14:0] sd_c;
	logic [63:0]        dval_c;
	logic [36:0]        drift_c;

	assign sd_c    = 15'(ea_n) - 15'sd6;
	assign dval_c  = scale(sd_c, ea_sum);
	assign drift_c = ea_side.dzero ? '0 :
		((dval_c > 64'(rbvf_pkg::DRIFT_MAX)) ? rbvf_pkg::DRIFT_MAX : dval_c[36:0]);

	logic            v_s4;
	logic [36:0]     drift_s4;
	rbvf_pkg::side_t side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			drift_s4 <= drift_c;
			side_s4  <= ea_side;
		end
	end

	// s5: x = e - drift, clamped
	logic signed [37:0] xw_c;
	logic signed [37:0] xcl_c;

	assign xw_c  = 38'(side_s4.e) - $signed({1'b0, drift_s4});
	assign xcl_c = (xw_c < X_LO) ? X_LO : ((xw_c > X_HI) ? X_HI : xw_c);

	logic            v_s5;
	logic [30:0]     x_s5;
	rbvf_pkg::side_t side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s5    <= xcl_c[30:0];
			side_s5 <= side_s4;
		end
	end

	// s6: |x| * log2(e)
	logic [30:0] xmag_c;
	logic [61:0] wprod_c;

	assign xmag_c  = x_s5[30] ? ~x_s5 + 31'd1 : x_s5;
	assign wprod_c = 62'(xmag_c) * 62'(rbvf_pkg::LOG2E_Q30);

	logic            v_s6;
	logic [61:0]     wprod_s6;
	logic            wneg_s6;
	rbvf_pkg::side_t side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			wprod_s6 <= wprod_c;
			wneg_s6  <= x_s5[30];
			side_s6  <= side_s5;
		end
	end

	// s7: w = x*log2(e) + log2(xi0)
	logic [ZW-1:0] wm_c;
	logic [ZW-1:0] w_c;

	assign wm_c = {6'b0, wprod_s6[61:28]};
	assign w_c  = (wneg_s6 ? ~wm_c + 40'd1 : wm_c) + ZW'(side_s6.log_xi0);

	logic            v_s7;
	logic [ZW-1:0]   w_s7;
	rbvf_pkg::side_t side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s7    <= w_c;
			side_s7 <= side_s6;
		end
	end

	// valid bits of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s2 <= log_v;
			v_s3 <= v_s2;
			v_s4 <= ea_v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	logic                          eb_v;
	logic signed [rbvf_pkg::N_W-1:0] eb_n;
	logic [31:0]                   eb_sum;
	rbvf_pkg::side_t               eb_side;

	rbvf_exp2 u_exp_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (v_s7),
		.z_i     (w_s7),
		.side_i  (side_s7),
		.valid_o (eb_v),
		.n_o     (eb_n),
		.sum_o   (eb_sum),
		.side_o  (eb_side)
	);

	// result in Q16.32, saturated; special cases override
	logic signed [14:0] so_c;
	logic [63:0]        oval_c;

	assign so_c        = 15'(eb_n) + 15'sd2;
	assign oval_c      = scale(so_c, eb_sum);
	assign res_valid_c = eb_v;

	always_comb begin
		res_c.status = eb_side.status;
		if (eb_side.status | eb_side.zero) begin
			res_c.variance_factor = '0;
		end else if (oval_c > 64'(rbvf_pkg::OUT_MAX)) begin
			res_c.variance_factor = rbvf_pkg::OUT_MAX;
		end else begin
			res_c.variance_factor = oval_c[47:0];
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (result_ready | ~out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (result_ready | ~out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res_c;
		end else if (push) begin
			skid_q <= res_c;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// checks
	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q & ~result_ready & res_valid_c))
		else $error("skid filled without a stalled output");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid & result.status) |-> (result.variance_factor == '0))
		else $error("error status with a nonzero result");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> $stable(v_s7) && $stable(eb_v))
		else $error("pipeline moved while the skid was full");

endmodule
